>>> rtl/core/derpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package derpd_pkg;

  // Long-form lengths with more octets than this are not decoded
  localparam int unsigned MaxLengthOctets = 4;
  // Width of the running byte position within a message
  localparam int unsigned IndexWidth = 32;

  localparam logic [7:0]  IdBoolean  = 8'h01;
  localparam logic [7:0]  IdInteger  = 8'h02;
  localparam logic [7:0]  LenIndef   = 8'h80;
  localparam logic [7:0]  LenReserved = 8'hFF;
  localparam logic [31:0] LenTooBig  = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_BOOLEAN = 2'd0,
    MODE_INTEGER = 2'd1,
    MODE_LENGTH  = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    CFG_DECODE_MODE   = 1'b0,
    CFG_ELEMENT_START = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_VALUE     = 3'd1,
    ST_UNIMPL_VALUE  = 3'd2,
    ST_INDEFINITE    = 3'd3,
    ST_BAD_LENGTH    = 3'd4,
    ST_UNIMPL_LENGTH = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_SKIP      = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_MORE  = 3'd2,
    PH_VALUE     = 3'd3,
    PH_DONE      = 3'd4
  } phase_e;

  typedef struct packed {
    logic [IndexWidth-1:0] pos;
    phase_e                phase;
    logic [6:0]            len_left;
    logic [31:0]           len_acc;
    logic [30:0]           val_left;
    logic [31:0]           val_acc;
    logic [7:0]            first_oct;
  } state_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] value;
    logic [31:0] stop;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/derpd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module derpd_step (
  input  derpd_pkg::state_t  cur_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  derpd_pkg::mode_e   mode_i,
  input  logic [31:0]        start_i,
  output derpd_pkg::state_t  nxt_o,
  output derpd_pkg::result_t res_o
);
  import derpd_pkg::*;

  logic                  len_only;
  logic [IndexWidth-1:0] start_idx;
  logic [63:0]           start_ext;
  logic [63:0]           pos_ext;
  logic [31:0]           acc_more;
  logic [31:0]           val_acc_new;
  logic [30:0]           val_left_new;
  logic [7:0]            first_new;
  logic [7:0]            second;
  logic                  lf_go;
  logic                  ld_go;
  logic [31:0]           ld_len;
  logic                  vd_go;
  result_t               vd_res;
  state_t                nxt;
  result_t               res;

  assign len_only  = mode_i[1];
  assign start_ext = {32'd0, start_i};
  assign start_idx = start_ext[IndexWidth-1:0];
  assign pos_ext   = {{(64 - IndexWidth){1'b0}}, cur_i.pos};

  // Saturate once the accumulator cannot take another octet
  assign acc_more     = (cur_i.len_acc > 32'h007F_FFFF) ? LenTooBig
                                                        : {cur_i.len_acc[23:0], byte_i};
  assign val_acc_new  = {cur_i.val_acc[23:0], byte_i};
  assign val_left_new = cur_i.val_left - 31'd1;
  assign first_new    = ({1'b0, cur_i.val_left} == cur_i.len_acc) ? byte_i : cur_i.first_oct;

  // End of value octets
  always_comb begin
    vd_res        = '0;
    vd_res.valid  = 1'b1;
    vd_res.status = ST_OK;
    vd_res.stop   = pos_ext[31:0];
    case (cur_i.len_acc[1:0])
      2'd2:    second = val_acc_new[7:0];
      2'd3:    second = val_acc_new[15:8];
      default: second = val_acc_new[23:16];
    endcase
    if (mode_i == MODE_BOOLEAN) begin
      if (cur_i.len_acc != 32'd1) begin
        vd_res.status = ST_BAD_VALUE;
      end else if (val_acc_new[7:0] == 8'hFF) begin
        vd_res.value = 32'd1;
      end else if (val_acc_new[7:0] != 8'h00) begin
        vd_res.status = ST_BAD_VALUE;
      end
    end else if (cur_i.len_acc > 32'd4) begin
      vd_res.status = ST_UNIMPL_VALUE;
    end else if (cur_i.len_acc >= 32'd2 &&
                 ((first_new == 8'h00 && !second[7]) ||
                  (first_new == 8'hFF && second[7]))) begin
      // redundant leading octet
      vd_res.status = ST_BAD_VALUE;
    end else begin
      vd_res.value = val_acc_new;
      if (first_new[7]) begin
        case (cur_i.len_acc[2:0])
          3'd1:    vd_res.value = val_acc_new | 32'hFFFF_FF00;
          3'd2:    vd_res.value = val_acc_new | 32'hFFFF_0000;
          3'd3:    vd_res.value = val_acc_new | 32'hFF00_0000;
          default: vd_res.value = val_acc_new;
        endcase
      end
    end
  end

  always_comb begin
    nxt        = cur_i;
    res        = '0;
    res.status = ST_OK;
    res.stop   = pos_ext[31:0];
    lf_go      = 1'b0;
    ld_go      = 1'b0;
    ld_len     = '0;
    vd_go      = 1'b0;

    case (cur_i.phase)
      PH_SKIP: begin
        if (cur_i.pos == start_idx) begin
          if (len_only) begin
            lf_go = 1'b1;
          end else if (byte_i == ((mode_i == MODE_BOOLEAN) ? IdBoolean : IdInteger)) begin
            nxt.phase = PH_LEN_FIRST;
          end else begin
            res.valid  = 1'b1;
            res.status = ST_BAD_VALUE;
          end
        end
      end
      PH_LEN_FIRST: begin
        lf_go = 1'b1;
      end
      PH_LEN_MORE: begin
        nxt.len_acc  = acc_more;
        nxt.len_left = cur_i.len_left - 7'd1;
        if (cur_i.len_left == 7'd1) begin
          ld_go  = 1'b1;
          ld_len = acc_more;
        end
      end
      PH_VALUE: begin
        nxt.first_oct = first_new;
        nxt.val_acc   = val_acc_new;
        nxt.val_left  = val_left_new;
        vd_go         = (val_left_new == '0);
      end
      default: ;
    endcase

    // first length octet
    if (lf_go) begin
      if (byte_i == LenIndef) begin
        res.valid  = 1'b1;
        res.status = len_only ? ST_INDEFINITE : ST_BAD_VALUE;
      end else if (!byte_i[7]) begin
        ld_go  = 1'b1;
        ld_len = {24'd0, byte_i};
      end else if (byte_i == LenReserved) begin
        res.valid  = 1'b1;
        res.status = len_only ? ST_BAD_LENGTH : ST_BAD_VALUE;
      end else begin
        nxt.len_left = byte_i[6:0];
        nxt.len_acc  = (byte_i[6:0] > 7'(MaxLengthOctets)) ? LenTooBig : '0;
        nxt.phase    = PH_LEN_MORE;
      end
    end

    // length complete
    if (ld_go) begin
      if (ld_len[31]) begin
        res.valid  = 1'b1;
        res.status = len_only ? ST_UNIMPL_LENGTH : ST_BAD_VALUE;
      end else if (len_only) begin
        res.valid = 1'b1;
        res.value = ld_len;
      end else if (ld_len == '0) begin
        res.valid  = 1'b1;
        res.status = ST_BAD_VALUE;
      end else begin
        nxt.phase    = PH_VALUE;
        nxt.len_acc  = ld_len;
        nxt.val_left = ld_len[30:0];
        nxt.val_acc  = '0;
      end
    end

    if (vd_go) begin
      res = vd_res;
    end

    if (res.valid) begin
      nxt.phase = PH_DONE;
    end

    if (last_i) begin
      // truncated element or start never reached
      if (!res.valid && cur_i.phase != PH_DONE) begin
        res.valid  = 1'b1;
        res.status = len_only ? ST_BAD_LENGTH : ST_BAD_VALUE;
        res.value  = '0;
      end
      nxt.pos   = '0;
      nxt.phase = PH_SKIP;
    end else begin
      nxt.pos = cur_i.pos + IndexWidth'(1);
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

`default_nettype wire

>>> rtl/core/der_primitive_decoder.sv
// Streaming decoder for one primitive DER element per message.
// Input channel: one message octet per beat on data_byte_i, with last_byte_i
// flagging the final octet. A beat is taken when in_valid_i is high and
// in_stall_o is low. Octets before the configured element_start are skipped,
// then one element is decoded as BOOLEAN, INTEGER or bare length octets.
// Output channel: exactly one result beat per message (status, value, stop
// index), taken when out_valid_o is high and out_stall_i is low. The result
// is registered when the deciding octet leaves the input register through
// the step logic, and is offered on the output from there.
// Throughput: one octet per cycle while in_stall_o is low; each octet
// passes one input register, one step of compare and shift-accumulate
// logic and, if it decides the element, the result register.
// Stalls: while a result waits under out_stall_i and the input register
// holds an octet, in_stall_o rises; otherwise octets keep flowing.
// Reset: asynchronous, active low; both registers empty, decoder back to
// skipping at byte position zero, decode_mode 0 and element_start 0.
// Configuration: cfg_we_i writes register cfg_idx_i (0 decode_mode,
// 1 element_start) with cfg_data_i; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module der_primitive_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         result_status_o,
  output logic signed [31:0] decoded_value_o,
  output logic [31:0]        stop_index_o
);
  import derpd_pkg::*;

  // configuration
  mode_e       mode_q;
  logic [31:0] start_q;

  // input register
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // decoder state and result register
  state_t      state_q, state_d;
  result_t     res_d;
  logic        out_valid_q;
  status_e     out_status_q;
  logic [31:0] out_value_q;
  logic [31:0] out_stop_q;

  logic        out_free;
  logic        advance;

  // result slot frees up this cycle, so the held octet can be decoded
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  derpd_step u_step (
    .cur_i   (state_q),
    .byte_i  (byte_q),
    .last_i  (last_q),
    .mode_i  (mode_q),
    .start_i (start_q),
    .nxt_o   (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOOLEAN;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DECODE_MODE:   mode_q  <= mode_e'(cfg_data_i[1:0]);
        CFG_ELEMENT_START: start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // all-zero state is position zero, skipping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && res_d.valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_d.valid) begin
      out_status_q <= res_d.status;
      out_value_q  <= res_d.value;
      out_stop_q   <= res_d.stop;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_status_o = out_status_q;
  assign decoded_value_o = signed'(out_value_q);
  assign stop_index_o    = out_stop_q;

endmodule

`default_nettype wire

>>> rtl/core/derpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module derpd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [2:0]         result_status_o,
  input  logic signed [31:0] decoded_value_o,
  input  logic [31:0]        stop_index_o
);
  import derpd_pkg::*;

  // a waiting result beat holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_status_o) &&
    $stable(decoded_value_o) && $stable(stop_index_o))
    else $error("result beat changed under stall");

  // input backpressure only comes from a blocked result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result slot");

  // errors always carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_status_o != ST_OK |-> decoded_value_o == 32'sd0)
    else $error("non-zero value with error status");

  // no result beat without an input octet offered before it or held over
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i) || $past(in_stall_o) ||
    $past(in_valid_i, 2))
    else $error("result beat without input octet");

endmodule

bind der_primitive_decoder derpd_checker u_derpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_status_o (result_status_o),
  .decoded_value_o (decoded_value_o),
  .stop_index_o    (stop_index_o)
);

`default_nettype wire

>>> dv/tb_der_primitive_decoder.sv
`timescale 1ns / 1ps

module tb_der_primitive_decoder;
  import derpd_pkg::*;

  localparam int unsigned IdleLimit = 3000;  // cycles without any beat
  localparam int unsigned HoldCycles = 300;  // long receiver hold-off
  localparam int unsigned SettleCycles = 4;  // octet passes input, result regs
  localparam int unsigned RandomOctets = 1020;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [31:0] stop;
  } decode_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [2:0] result_status_o;
  logic signed [31:0] decoded_value_o;
  logic [31:0] stop_index_o;

  der_primitive_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_status_o(result_status_o),
    .decoded_value_o(decoded_value_o),
    .stop_index_o   (stop_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder mirror: registers and parse state
  mode_e       mode_r;
  logic [31:0] start_r;
  logic [31:0] pos_m;
  phase_e      phase_m;
  logic [6:0]  len_left_m;
  logic [31:0] len_acc_m;
  logic [31:0] val_left_m;
  logic [31:0] val_acc_m;
  logic [7:0]  first_m;
  bit          given_m;

  decode_res_t decoded_q[$];
  decode_res_t head;
  logic [7:0]  frame_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned octets_sent = 0;
  int unsigned rx_run = 0;
  int unsigned rx_hold_left = 0;
  bit          hold_req = 1'b0;
  bit          calm = 1'b0;  // no random idling on either side

  function automatic void clear_model();
    mode_r = MODE_BOOLEAN;
    start_r = '0;
    pos_m = '0;
    phase_m = PH_SKIP;
    len_left_m = '0;
    len_acc_m = '0;
    val_left_m = '0;
    val_acc_m = '0;
    first_m = '0;
    given_m = 1'b0;
  endfunction

  function automatic void post_result(status_e st, logic [31:0] val);
    decode_res_t r;
    r.status = st;
    r.value = val;
    r.stop = pos_m;
    decoded_q.push_back(r);
    given_m = 1'b1;
    phase_m = PH_DONE;
  endfunction

  // length faults only keep their own code in length-only modes
  function automatic void fail_length(status_e code);
    post_result(mode_r[1] ? code : ST_BAD_VALUE, '0);
  endfunction

  function automatic void close_length(logic [31:0] len);
    if (len > 32'h7FFF_FFFF) begin
      fail_length(ST_UNIMPL_LENGTH);
    end else if (mode_r[1]) begin
      post_result(ST_OK, len);
    end else if (len == 0) begin
      post_result(ST_BAD_VALUE, '0);
    end else begin
      phase_m = PH_VALUE;
      len_acc_m = len;
      val_left_m = len;
      val_acc_m = '0;
    end
  endfunction

  function automatic void open_length(logic [7:0] b);
    if (b == LenIndef) begin
      fail_length(ST_INDEFINITE);
    end else if (!b[7]) begin
      close_length({24'd0, b});
    end else if (b == LenReserved) begin
      fail_length(ST_BAD_LENGTH);
    end else begin
      len_left_m = b[6:0];
      len_acc_m = (b[6:0] > MaxLengthOctets) ? LenTooBig : '0;
      phase_m = PH_LEN_MORE;
    end
  endfunction

  function automatic void close_value();
    logic [31:0] len;
    logic [31:0] acc;
    logic [7:0]  second;
    len = len_acc_m;
    acc = val_acc_m;
    if (mode_r == MODE_BOOLEAN) begin
      if (len != 1) post_result(ST_BAD_VALUE, '0);
      else if (acc[7:0] == 8'hFF) post_result(ST_OK, 32'd1);
      else if (acc[7:0] == 8'h00) post_result(ST_OK, 32'd0);
      else post_result(ST_BAD_VALUE, '0);
    end else if (len > 4) begin
      post_result(ST_UNIMPL_VALUE, '0);
    end else begin
      second = (len >= 2) ? 8'(acc >> (8 * (len - 2))) : 8'h00;
      if (len >= 2 && ((first_m == 8'h00 && !second[7]) ||
                       (first_m == 8'hFF && second[7]))) begin
        post_result(ST_BAD_VALUE, '0);  // redundant leading octet
      end else begin
        if (first_m[7] && len < 4) acc = acc | (32'hFFFF_FFFF << (8 * len));
        post_result(ST_OK, acc);
      end
    end
  endfunction

  // One accepted octet through the mirror; results go to decoded_q
  function automatic void decode_octet(logic [7:0] b, bit last);
    case (phase_m)
      PH_SKIP: begin
        if (pos_m == start_r) begin
          if (mode_r[1]) open_length(b);
          else if (b == ((mode_r == MODE_BOOLEAN) ? IdBoolean : IdInteger))
            phase_m = PH_LEN_FIRST;
          else post_result(ST_BAD_VALUE, '0);
        end
      end
      PH_LEN_FIRST: begin
        open_length(b);
      end
      PH_LEN_MORE: begin
        if (len_acc_m > 32'h007F_FFFF) len_acc_m = LenTooBig;
        else len_acc_m = {len_acc_m[23:0], b};
        len_left_m = len_left_m - 7'd1;
        if (len_left_m == 0) close_length(len_acc_m);
      end
      PH_VALUE: begin
        if (val_left_m == len_acc_m) first_m = b;
        val_acc_m = {val_acc_m[23:0], b};
        val_left_m = val_left_m - 1;
        if (val_left_m == 0) close_value();
      end
      default: ;
    endcase
    if (last) begin
      // truncated element, or start never reached
      if (!given_m) post_result(mode_r[1] ? ST_BAD_LENGTH : ST_BAD_VALUE, '0);
      pos_m = '0;
      phase_m = PH_SKIP;
      given_m = 1'b0;
    end else begin
      pos_m = pos_m + 1;
    end
  endfunction

  // mostly short, now and then long
  function automatic int unsigned pick_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always begin : rx_side
    @(negedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_run > 0) begin
      rx_run--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rx_run = pick_hold() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result check, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result beat: status %0d value %0h stop %0d",
               result_status_o, decoded_value_o, stop_index_o);
        mismatch_cnt++;
      end else begin
        head = decoded_q.pop_front();
        if (result_status_o !== head.status) begin
          $error("result_status: expected %0d, actual %0d", head.status, result_status_o);
          mismatch_cnt++;
        end
        if (decoded_value_o !== head.value) begin
          $error("decoded_value: expected %0h, actual %0h", head.value, decoded_value_o);
          mismatch_cnt++;
        end
        if (stop_index_o !== head.stop) begin
          $error("stop_index: expected %0d, actual %0d", head.stop, stop_index_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_octet(input logic [7:0] b, input bit last);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_hold();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_octet(b, last);
    octets_sent++;
  endtask

  // close=0 leaves the message open after the final octet
  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_q.size(); i++)
      send_octet(frame_q[i], close && (i == frame_q.size() - 1));
    frame_q.delete();
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DECODE_MODE) mode_r = mode_e'(val[1:0]);
    else start_r = val;
  endtask

  task automatic set_config(input mode_e mode, input logic [31:0] start);
    settle_idle();
    write_cfg(CFG_DECODE_MODE, 32'(mode));
    write_cfg(CFG_ELEMENT_START, start);
  endtask

  function automatic void push_length(logic [31:0] len, bit long_form, int unsigned pad);
    int unsigned n;
    n = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
    if (!long_form && len < 128) begin
      frame_q.push_back(len[7:0]);
    end else begin
      frame_q.push_back(8'h80 | 8'(n + pad));
      repeat (pad) frame_q.push_back(8'h00);
      for (int i = n - 1; i >= 0; i--) frame_q.push_back(8'(len >> (8 * i)));
    end
  endfunction

  // One message: mostly a well-formed element for the current mode with
  // random content, some broken or truncated, a few pure noise
  function automatic void build_frame();
    int unsigned r, len, skip, sel, cut;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end else begin
      skip = (start_r < 16) ? start_r : $urandom_range(0, 4);
      repeat (skip) frame_q.push_back(8'($urandom));
      if (mode_r[1]) begin
        r = $urandom_range(0, 9);
        if (r == 0) frame_q.push_back(LenIndef);
        else if (r == 1) frame_q.push_back(LenReserved);
        else if (r < 5) frame_q.push_back(8'($urandom_range(0, 127)));
        else begin
          len = $urandom_range(1, 6);
          frame_q.push_back(8'h80 | 8'(len));
          repeat (len) frame_q.push_back(8'($urandom));
        end
      end else begin
        if ($urandom_range(0, 9) == 0) frame_q.push_back(8'($urandom));
        else frame_q.push_back((mode_r == MODE_BOOLEAN) ? IdBoolean : IdInteger);
        if (mode_r == MODE_BOOLEAN)
          len = ($urandom_range(0, 4) != 0) ? 1 : $urandom_range(0, 3);
        else
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
        r = $urandom_range(0, 19);
        if (r == 0) begin
          frame_q.push_back(LenIndef);
        end else if (r == 1) begin
          frame_q.push_back(LenReserved);
        end else if (r == 2) begin
          frame_q.push_back(8'h85);  // too many length octets
          repeat (5) frame_q.push_back(8'h00);
        end else if (r == 3) begin
          frame_q.push_back(8'h84);  // length above the signed range
          frame_q.push_back(8'h80);
          repeat (3) frame_q.push_back(8'h00);
        end else begin
          push_length(len, $urandom_range(0, 3) == 0, $urandom_range(0, 2));
          for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 3);
            if (i == 0 && sel == 0) frame_q.push_back(8'h00);
            else if (i == 0 && sel == 1) frame_q.push_back(8'hFF);
            else frame_q.push_back(8'($urandom));
          end
        end
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 6) == 0 && frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        repeat (cut) void'(frame_q.pop_back());
      end
    end
  endfunction

  task automatic test_boolean();
    set_config(MODE_BOOLEAN, 32'd0);
    frame_q = '{8'h01, 8'h01, 8'hFF}; send_frame(1'b1);
    frame_q = '{8'h01, 8'h01, 8'h00}; send_frame(1'b1);
    frame_q = '{8'h01, 8'h01, 8'h7E}; send_frame(1'b1);
    frame_q = '{8'h05};               send_frame(1'b1);  // wrong identifier
  endtask

  task automatic test_integer();
    set_config(MODE_INTEGER, 32'd0);
    frame_q = '{8'h02, 8'h04, 8'h80, 8'h00, 8'h00, 8'h00}; send_frame(1'b1);
    frame_q = '{8'h02, 8'h01, 8'hFF};        send_frame(1'b1);
    frame_q = '{8'h02, 8'h02, 8'h00, 8'h7F}; send_frame(1'b1);  // redundant zero
    frame_q = '{8'h02, 8'h00, 8'hAA};        send_frame(1'b1);  // empty integer
    frame_q = '{8'h02, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05}; send_frame(1'b1);
  endtask

  task automatic test_length();
    set_config(MODE_LENGTH, 32'd0);
    frame_q = '{8'h80};                             send_frame(1'b1);
    frame_q = '{8'hFF};                             send_frame(1'b1);
    frame_q = '{8'h84, 8'h7F, 8'hFF, 8'hFF, 8'hFF}; send_frame(1'b1);
    frame_q = '{8'h84, 8'h80, 8'h00, 8'h00, 8'h00}; send_frame(1'b1);
    set_config(MODE_RSVD, 32'd2);
    frame_q = '{8'hAA, 8'hBB, 8'h7F};               send_frame(1'b1);
  endtask

  task automatic test_truncation_and_mode_switch();
    set_config(MODE_LENGTH, 32'hFFFF_FFFF);  // element never reached
    frame_q = '{8'h00, 8'h11}; send_frame(1'b1);
    // integer header taken, then boolean rules for the value octet
    set_config(MODE_INTEGER, 32'd0);
    frame_q = '{8'h02, 8'h01}; send_frame(1'b0);
    settle_idle();
    write_cfg(CFG_DECODE_MODE, 32'(MODE_BOOLEAN));
    frame_q = '{8'hFF};        send_frame(1'b1);
  endtask

  task automatic test_backpressure();
    set_config(MODE_LENGTH, 32'd0);
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (16) begin
      frame_q.push_back(8'($urandom_range(0, 127)));
      send_frame(1'b1);
    end
    calm = 1'b0;
    settle_idle();  // sender waits for every result
  endtask

  task automatic test_random();
    int unsigned r;
    mode_e mode;
    logic [31:0] start;
    octets_sent = 0;
    while (octets_sent < RandomOctets) begin
      r = $urandom_range(0, 9);
      mode = (r < 3) ? MODE_BOOLEAN : (r < 6) ? MODE_INTEGER :
             (r < 9) ? MODE_LENGTH : MODE_RSVD;
      r = $urandom_range(0, 19);
      start = (r < 14) ? $urandom_range(0, 3) : (r < 18) ? $urandom_range(4, 12) :
              (r == 18) ? 32'hFFFF_FFFF : $urandom;
      set_config(mode, start);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(15, 30)) begin
        build_frame();
        send_frame(1'b1);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    clear_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_boolean();
    test_integer();
    test_length();
    test_truncation_and_mode_switch();
    test_backpressure();
    test_random();
    settle_idle();
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
